// ===== rtl/dtu_pkg.sv =====
// Shared types and codes for the 8085 data-transfer unit.
// Used by the front end, the execution unit and the top level; no dependencies.
`timescale 1ns / 1ps

package dtu_pkg;

   // Function codes of an incoming word
   typedef enum logic [3:0] {
      FN_MVI      = 4'd0,
      FN_MOV      = 4'd1,
      FN_LDA      = 4'd2,
      FN_LDAX     = 4'd3,
      FN_LXI      = 4'd4,
      FN_LHLD     = 4'd5,
      FN_STA      = 4'd6,
      FN_STAX     = 4'd7,
      FN_SHLD     = 4'd8,
      FN_XCHG     = 4'd9,
      FN_SPHL     = 4'd10,
      FN_XTHL     = 4'd11,
      FN_MEMWRITE = 4'd12,
      FN_MEMREAD  = 4'd13
   } func_type;

   // Register codes
   localparam logic [2:0] CODE_B = 3'd0;
   localparam logic [2:0] CODE_C = 3'd1;
   localparam logic [2:0] CODE_D = 3'd2;
   localparam logic [2:0] CODE_E = 3'd3;
   localparam logic [2:0] CODE_H = 3'd4;
   localparam logic [2:0] CODE_L = 3'd5;
   localparam logic [2:0] CODE_M = 3'd6;
   localparam logic [2:0] CODE_A = 3'd7;

   // Register pair codes
   localparam logic [1:0] PAIR_BC = 2'd0;
   localparam logic [1:0] PAIR_DE = 2'd1;
   localparam logic [1:0] PAIR_HL = 2'd2;
   localparam logic [1:0] PAIR_SP = 2'd3;

   // Operation classes handed from the front end to the execution unit
   typedef enum logic [3:0] {
      OP_NONE,
      OP_MOVE,
      OP_STORE,
      OP_LOAD,
      OP_PEEK,
      OP_LXI,
      OP_LHLD,
      OP_SHLD,
      OP_XCHG,
      OP_SPHL,
      OP_XTHL
   } op_kind_type;

   // Where a memory address comes from
   typedef enum logic [2:0] {
      AS_DIRECT,
      AS_BC,
      AS_DE,
      AS_HL,
      AS_SP
   } addr_sel_type;

   // Decoded operation
   typedef struct packed {
      op_kind_type  kind;
      logic         status;
      logic [2:0]   dst;
      logic [2:0]   src;
      logic         use_imm;
      logic [1:0]   pair;
      logic [7:0]   imm;
      logic [15:0]  addr;
      addr_sel_type addr_sel;
   } op_type;

   // Result word
   typedef struct packed {
      logic        status;
      logic [7:0]  read_byte;
      logic [7:0]  acc;
      logic [7:0]  reg_b;
      logic [7:0]  reg_c;
      logic [7:0]  reg_d;
      logic [7:0]  reg_e;
      logic [7:0]  reg_h;
      logic [7:0]  reg_l;
      logic [15:0] stack_ptr;
   } rsp_type;

endpackage

// ===== rtl/dtu_fifo.sv =====
// Two-entry first-in first-out queue for any packed word type.
// Used between front end and execution unit and on the result side; no dependencies.
`timescale 1ns / 1ps

module dtu_fifo #(
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_item = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/dtu_front.sv =====
// Front end: decodes and classifies incoming words and queues them for execution.
// Depends on dtu_pkg and dtu_fifo.
`timescale 1ns / 1ps

module dtu_front (
   input  logic           clock,
   input  logic           reset,
   input  logic           hold,
   input  logic           push,
   output logic           full,
   input  logic [3:0]     req_func,
   input  logic [2:0]     req_dst_reg,
   input  logic [2:0]     req_src_reg,
   input  logic [1:0]     req_reg_pair,
   input  logic [7:0]     req_imm_byte,
   input  logic [15:0]    req_addr_word,
   input  logic           op_pop,
   output dtu_pkg::op_type op_head,
   output logic           op_empty
);
   import dtu_pkg::*;

   op_type dec;
   logic   queue_full;
   logic   queue_push;

   assign full       = queue_full || hold;
   assign queue_push = push && !full;

   // Classify the word and mark illegal pair or function codes
   always_comb begin
      dec.kind     = OP_NONE;
      dec.status   = 1'b0;
      dec.dst      = req_dst_reg;
      dec.src      = req_src_reg;
      dec.use_imm  = 1'b0;
      dec.pair     = req_reg_pair;
      dec.imm      = req_imm_byte;
      dec.addr     = req_addr_word;
      dec.addr_sel = AS_DIRECT;
      case (req_func)
         FN_MVI: begin
            dec.use_imm = 1'b1;
            if (req_dst_reg == CODE_M) begin
               dec.kind     = OP_STORE;
               dec.addr_sel = AS_HL;
            end else begin
               dec.kind = OP_MOVE;
            end
         end
         FN_MOV: begin
            if (req_dst_reg == CODE_M && req_src_reg == CODE_M) begin
               dec.kind = OP_NONE;
            end else if (req_dst_reg == CODE_M) begin
               dec.kind     = OP_STORE;
               dec.addr_sel = AS_HL;
            end else if (req_src_reg == CODE_M) begin
               dec.kind     = OP_LOAD;
               dec.addr_sel = AS_HL;
            end else begin
               dec.kind = OP_MOVE;
            end
         end
         FN_LDA: begin
            dec.kind = OP_LOAD;
            dec.dst  = CODE_A;
         end
         FN_LDAX: begin
            dec.dst = CODE_A;
            if (req_reg_pair == PAIR_BC) begin
               dec.kind     = OP_LOAD;
               dec.addr_sel = AS_BC;
            end else if (req_reg_pair == PAIR_DE) begin
               dec.kind     = OP_LOAD;
               dec.addr_sel = AS_DE;
            end else begin
               dec.status = 1'b1;
            end
         end
         FN_LXI: begin
            if (req_reg_pair == PAIR_SP) begin
               dec.status = 1'b1;
            end else begin
               dec.kind = OP_LXI;
            end
         end
         FN_LHLD: dec.kind = OP_LHLD;
         FN_STA: begin
            dec.kind = OP_STORE;
            dec.src  = CODE_A;
         end
         FN_STAX: begin
            dec.src = CODE_A;
            case (req_reg_pair)
               PAIR_BC: begin
                  dec.kind     = OP_STORE;
                  dec.addr_sel = AS_BC;
               end
               PAIR_DE: begin
                  dec.kind     = OP_STORE;
                  dec.addr_sel = AS_DE;
               end
               PAIR_HL: begin
                  dec.kind     = OP_STORE;
                  dec.addr_sel = AS_HL;
               end
               default: dec.status = 1'b1;
            endcase
         end
         FN_SHLD: dec.kind = OP_SHLD;
         FN_XCHG: dec.kind = OP_XCHG;
         FN_SPHL: dec.kind = OP_SPHL;
         FN_XTHL: begin
            dec.kind     = OP_XTHL;
            dec.addr_sel = AS_SP;
         end
         FN_MEMWRITE: begin
            dec.kind    = OP_STORE;
            dec.use_imm = 1'b1;
         end
         FN_MEMREAD: dec.kind = OP_PEEK;
         default: dec.status = 1'b1;
      endcase
   end

   // Queue decoded operations for the execution unit
   dtu_fifo #(
      .item_type(op_type)
   ) u_op_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (queue_push),
      .push_item(dec),
      .full     (queue_full),
      .pop      (op_pop),
      .pop_item (op_head),
      .empty    (op_empty)
   );

endmodule

// ===== rtl/dtu_exec.sv =====
// Execution unit: register file, byte memory and the per-operation sequencer.
// Depends on dtu_pkg; clears the memory after reset before taking operations.
`timescale 1ns / 1ps

module dtu_exec #(
   parameter int ADDR_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             op_valid,
   input  dtu_pkg::op_type  op,
   output logic             op_pop,
   input  logic             rsp_full,
   output logic             rsp_push,
   output dtu_pkg::rsp_type rsp,
   output logic             clearing
);
   import dtu_pkg::*;

   localparam int MEM_DEPTH = 1 << ADDR_BITS;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_THIRD
   } phase_type;

   phase_type            phase_ff;
   phase_type            phase_in;
   logic [7:0]           acc_ff;
   logic [7:0]           acc_in;
   logic [7:0]           gpr_ff [6];
   logic [7:0]           gpr_in [6];
   logic [15:0]          sp_ff;
   logic [15:0]          sp_in;
   logic                 clear_ff;
   logic [ADDR_BITS-1:0] clr_addr_ff;
   logic [7:0]           mem_ff [MEM_DEPTH];
   logic [7:0]           rdata_ff;

   logic                 step_en;
   logic                 done;
   logic [7:0]           rd_byte;
   logic [15:0]          base;
   logic [ADDR_BITS-1:0] addr0;
   logic [ADDR_BITS-1:0] addr1;
   logic [7:0]           src_reg_val;
   logic [7:0]           src_val;
   logic                 mem_en;
   logic                 mem_we;
   logic [ADDR_BITS-1:0] mem_addr;
   logic [7:0]           mem_wd;

   assign clearing = clear_ff;
   assign step_en  = op_valid && !clear_ff && !rsp_full;

   // Pick the memory address for this operation
   always_comb begin
      case (op.addr_sel)
         AS_BC:   base = {gpr_ff[CODE_B], gpr_ff[CODE_C]};
         AS_DE:   base = {gpr_ff[CODE_D], gpr_ff[CODE_E]};
         AS_HL:   base = {gpr_ff[CODE_H], gpr_ff[CODE_L]};
         AS_SP:   base = sp_ff;
         default: base = op.addr;
      endcase
      addr0 = base[ADDR_BITS-1:0];
      addr1 = addr0 + {{(ADDR_BITS-1){1'b0}}, 1'b1};
   end

   // Select the source byte
   always_comb begin
      case (op.src)
         CODE_A:  src_reg_val = acc_ff;
         CODE_M:  src_reg_val = 8'd0;
         default: src_reg_val = gpr_ff[op.src];
      endcase
      src_val = op.use_imm ? op.imm : src_reg_val;
   end

   // Sequence one operation: memory access and register updates per phase
   always_comb begin
      acc_in   = acc_ff;
      gpr_in   = gpr_ff;
      sp_in    = sp_ff;
      phase_in = phase_ff;
      mem_en   = 1'b0;
      mem_we   = 1'b0;
      mem_addr = addr0;
      mem_wd   = src_val;
      done     = 1'b0;
      rd_byte  = 8'd0;
      if (clear_ff) begin
         mem_en   = 1'b1;
         mem_we   = 1'b1;
         mem_addr = clr_addr_ff;
         mem_wd   = 8'd0;
      end else if (step_en) begin
         case (op.kind)
            OP_MOVE: begin
               if (op.dst == CODE_A) begin
                  acc_in = src_val;
               end else if (op.dst != CODE_M) begin
                  gpr_in[op.dst] = src_val;
               end
               done = 1'b1;
            end
            OP_STORE: begin
               mem_en = 1'b1;
               mem_we = 1'b1;
               done   = 1'b1;
            end
            OP_LOAD, OP_PEEK: begin
               if (phase_ff == PH_FIRST) begin
                  mem_en   = 1'b1;
                  phase_in = PH_SECOND;
               end else begin
                  if (op.kind == OP_PEEK) begin
                     rd_byte = rdata_ff;
                  end else if (op.dst == CODE_A) begin
                     acc_in = rdata_ff;
                  end else if (op.dst != CODE_M) begin
                     gpr_in[op.dst] = rdata_ff;
                  end
                  done = 1'b1;
               end
            end
            OP_LXI: begin
               case (op.pair)
                  PAIR_BC: begin
                     gpr_in[CODE_B] = op.addr[15:8];
                     gpr_in[CODE_C] = op.addr[7:0];
                  end
                  PAIR_DE: begin
                     gpr_in[CODE_D] = op.addr[15:8];
                     gpr_in[CODE_E] = op.addr[7:0];
                  end
                  PAIR_HL: begin
                     gpr_in[CODE_H] = op.addr[15:8];
                     gpr_in[CODE_L] = op.addr[7:0];
                  end
                  default: ;
               endcase
               done = 1'b1;
            end
            OP_LHLD: begin
               case (phase_ff)
                  PH_FIRST: begin
                     mem_en   = 1'b1;
                     phase_in = PH_SECOND;
                  end
                  PH_SECOND: begin
                     mem_en         = 1'b1;
                     mem_addr       = addr1;
                     gpr_in[CODE_L] = rdata_ff;
                     phase_in       = PH_THIRD;
                  end
                  default: begin
                     gpr_in[CODE_H] = rdata_ff;
                     done           = 1'b1;
                  end
               endcase
            end
            OP_SHLD: begin
               mem_en = 1'b1;
               mem_we = 1'b1;
               if (phase_ff == PH_FIRST) begin
                  mem_wd   = gpr_ff[CODE_L];
                  phase_in = PH_SECOND;
               end else begin
                  mem_addr = addr1;
                  mem_wd   = gpr_ff[CODE_H];
                  done     = 1'b1;
               end
            end
            OP_XCHG: begin
               gpr_in[CODE_H] = gpr_ff[CODE_D];
               gpr_in[CODE_D] = gpr_ff[CODE_H];
               gpr_in[CODE_L] = gpr_ff[CODE_E];
               gpr_in[CODE_E] = gpr_ff[CODE_L];
               done           = 1'b1;
            end
            OP_SPHL: begin
               sp_in = {gpr_ff[CODE_H], gpr_ff[CODE_L]};
               done  = 1'b1;
            end
            OP_XTHL: begin
               // Memory reads the old byte while the register byte goes in
               case (phase_ff)
                  PH_FIRST: begin
                     mem_en   = 1'b1;
                     mem_we   = 1'b1;
                     mem_wd   = gpr_ff[CODE_L];
                     phase_in = PH_SECOND;
                  end
                  PH_SECOND: begin
                     mem_en         = 1'b1;
                     mem_we         = 1'b1;
                     mem_addr       = addr1;
                     mem_wd         = gpr_ff[CODE_H];
                     gpr_in[CODE_L] = rdata_ff;
                     phase_in       = PH_THIRD;
                  end
                  default: begin
                     gpr_in[CODE_H] = rdata_ff;
                     done           = 1'b1;
                  end
               endcase
            end
            default: done = 1'b1;
         endcase
         if (done) begin
            phase_in = PH_FIRST;
         end
      end
   end

   // Hand the finished word to the result queue
   assign op_pop   = done;
   assign rsp_push = done;
   always_comb begin
      rsp.status    = op.status;
      rsp.read_byte = rd_byte;
      rsp.acc       = acc_in;
      rsp.reg_b     = gpr_in[CODE_B];
      rsp.reg_c     = gpr_in[CODE_C];
      rsp.reg_d     = gpr_in[CODE_D];
      rsp.reg_e     = gpr_in[CODE_E];
      rsp.reg_h     = gpr_in[CODE_H];
      rsp.reg_l     = gpr_in[CODE_L];
      rsp.stack_ptr = sp_in;
   end

   // Hold architectural state, phase and the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= 8'd0;
         gpr_ff      <= '{default: 8'd0};
         sp_ff       <= 16'd0;
         phase_ff    <= PH_FIRST;
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         acc_ff   <= acc_in;
         gpr_ff   <= gpr_in;
         sp_ff    <= sp_in;
         phase_ff <= phase_in;
         if (clear_ff) begin
            clr_addr_ff <= clr_addr_ff + {{(ADDR_BITS-1){1'b0}}, 1'b1};
            if (&clr_addr_ff) begin
               clear_ff <= 1'b0;
            end
         end
      end
   end

   // Single-port byte memory, read-first
   always_ff @(posedge clock) begin
      if (mem_en) begin
         if (mem_we) begin
            mem_ff[mem_addr] <= mem_wd;
         end
         rdata_ff <= mem_ff[mem_addr];
      end
   end

endmodule

// ===== rtl/cpu8085_data_transfer_unit_top.sv =====
// Top level of the 8085 data-transfer unit: front end, execution unit, result queue.
// Depends on dtu_pkg, dtu_fifo, dtu_front and dtu_exec.
//
// Usage:
//   Instruction words enter as a queue: a word is taken on an edge with push high
//   and full low. Each word yields exactly one result word (status, read byte and
//   the full register set); it waits on the rsp_ ports while empty is low and
//   leaves on an edge with pop high.
//   A two-entry queue decouples decode from execution, and a two-entry result
//   queue decouples execution from the receiver, so new words are taken while
//   results wait.
//   An accepted word is registered in the input queue and its result in the
//   result queue before it can be popped.
//   Throughput: 1 word per cycle for register-only and single-write words while
//   the result queue has room; single reads and SHLD step through PH_FIRST and
//   PH_SECOND, LHLD and XTHL on through PH_THIRD; a word finishes before the next
//   starts, as set by the single-port byte memory with registered read data.
//   Reset zeroes all registers, then a clearing sweep writes zero to every one of
//   the 2^ADDR_BITS memory bytes, one per cycle; full stays high for those cycles.
//   When the receiver stalls, the result queue fills, execution halts and the
//   input queue backs up until full rises.
`timescale 1ns / 1ps

module cpu8085_data_transfer_unit_top #(
   parameter int ADDR_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [3:0]  req_func,
   input  logic [2:0]  req_dst_reg,
   input  logic [2:0]  req_src_reg,
   input  logic [1:0]  req_reg_pair,
   input  logic [7:0]  req_imm_byte,
   input  logic [15:0] req_addr_word,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_status,
   output logic [7:0]  rsp_read_byte,
   output logic [7:0]  rsp_acc,
   output logic [7:0]  rsp_reg_b,
   output logic [7:0]  rsp_reg_c,
   output logic [7:0]  rsp_reg_d,
   output logic [7:0]  rsp_reg_e,
   output logic [7:0]  rsp_reg_h,
   output logic [7:0]  rsp_reg_l,
   output logic [15:0] rsp_stack_ptr
);
   import dtu_pkg::*;

   op_type  op_head;
   logic    op_empty;
   logic    op_pop;
   logic    clearing;
   logic    rsp_push;
   logic    rsp_q_full;
   rsp_type rsp_new;
   rsp_type rsp_head;

   // Decode and queue incoming words
   dtu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .hold         (clearing),
      .push         (push),
      .full         (full),
      .req_func     (req_func),
      .req_dst_reg  (req_dst_reg),
      .req_src_reg  (req_src_reg),
      .req_reg_pair (req_reg_pair),
      .req_imm_byte (req_imm_byte),
      .req_addr_word(req_addr_word),
      .op_pop       (op_pop),
      .op_head      (op_head),
      .op_empty     (op_empty)
   );

   // Execute queued operations
   dtu_exec #(
      .ADDR_BITS(ADDR_BITS)
   ) u_exec (
      .clock   (clock),
      .reset   (reset),
      .op_valid(!op_empty),
      .op      (op_head),
      .op_pop  (op_pop),
      .rsp_full(rsp_q_full),
      .rsp_push(rsp_push),
      .rsp     (rsp_new),
      .clearing(clearing)
   );

   // Buffer result words for the receiver
   dtu_fifo #(
      .item_type(rsp_type)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .push_item(rsp_new),
      .full     (rsp_q_full),
      .pop      (pop),
      .pop_item (rsp_head),
      .empty    (empty)
   );

   assign rsp_status    = rsp_head.status;
   assign rsp_read_byte = rsp_head.read_byte;
   assign rsp_acc       = rsp_head.acc;
   assign rsp_reg_b     = rsp_head.reg_b;
   assign rsp_reg_c     = rsp_head.reg_c;
   assign rsp_reg_d     = rsp_head.reg_d;
   assign rsp_reg_e     = rsp_head.reg_e;
   assign rsp_reg_h     = rsp_head.reg_h;
   assign rsp_reg_l     = rsp_head.reg_l;
   assign rsp_stack_ptr = rsp_head.stack_ptr;

   // A result is never pushed into a full result queue
   assert property (@(posedge clock) disable iff (reset) rsp_push |-> !rsp_q_full)
      else $error("result pushed while result queue full");

   // An operation retires only when one is queued
   assert property (@(posedge clock) disable iff (reset) op_pop |-> !op_empty)
      else $error("operation retired from empty queue");

   // No word is taken and no result made during the memory clearing sweep
   assert property (@(posedge clock) disable iff (reset) clearing |-> full && !rsp_push)
      else $error("activity during memory clearing");

endmodule

// ===== tb/cpu8085_data_transfer_unit_top_test.sv =====
// Self-checking test of the 8085 data-transfer unit: directed, random, backpressure
// and streaming words, each result checked against an in-bench register/memory model.
// Depends on dtu_pkg and cpu8085_data_transfer_unit_top.
`timescale 1ns / 1ps

module cpu8085_data_transfer_unit_top_test;
   import dtu_pkg::*;

   localparam int ADDR_BITS = 16;
   localparam int MEM_WORDS = 1 << ADDR_BITS;
   localparam int HOLD_CYCLES = 60;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [3:0] FN_SPARE_LO = 4'd14;
   localparam logic [3:0] FN_SPARE_HI = 4'd15;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        pop = 1'b0;
   logic [3:0]  req_func = '0;
   logic [2:0]  req_dst_reg = '0;
   logic [2:0]  req_src_reg = '0;
   logic [1:0]  req_reg_pair = '0;
   logic [7:0]  req_imm_byte = '0;
   logic [15:0] req_addr_word = '0;
   logic        full;
   logic        empty;
   logic        rsp_status;
   logic [7:0]  rsp_read_byte;
   logic [7:0]  rsp_acc;
   logic [7:0]  rsp_reg_b;
   logic [7:0]  rsp_reg_c;
   logic [7:0]  rsp_reg_d;
   logic [7:0]  rsp_reg_e;
   logic [7:0]  rsp_reg_h;
   logic [7:0]  rsp_reg_l;
   logic [15:0] rsp_stack_ptr;

   // Model of the architectural state; reset leaves everything zero
   bit [7:0]  acc_m;
   bit [7:0]  gpr_m [6];
   bit [15:0] sp_m;
   bit [7:0]  mem_m [MEM_WORDS];

   rsp_type transfer_results_q [$];
   int  errors = 0;
   int  words_sent = 0;
   int  words_checked = 0;
   int  illegal_words = 0;
   int  full_waits = 0;
   bit  idle_enable = 1'b1;
   bit  hold_request = 1'b0;
   int  hold_left = 0;
   int  stall_left = 0;

   cpu8085_data_transfer_unit_top #(.ADDR_BITS(ADDR_BITS)) u_dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_func(req_func), .req_dst_reg(req_dst_reg), .req_src_reg(req_src_reg),
      .req_reg_pair(req_reg_pair), .req_imm_byte(req_imm_byte),
      .req_addr_word(req_addr_word),
      .empty(empty), .pop(pop),
      .rsp_status(rsp_status), .rsp_read_byte(rsp_read_byte), .rsp_acc(rsp_acc),
      .rsp_reg_b(rsp_reg_b), .rsp_reg_c(rsp_reg_c), .rsp_reg_d(rsp_reg_d),
      .rsp_reg_e(rsp_reg_e), .rsp_reg_h(rsp_reg_h), .rsp_reg_l(rsp_reg_l),
      .rsp_stack_ptr(rsp_stack_ptr)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Fold an address (possibly address+1) into the memory width
   function automatic logic [15:0] wrap_addr(input logic [16:0] a);
      return a[15:0] & 16'(MEM_WORDS - 1);
   endfunction

   function automatic logic [15:0] hl_addr();
      return wrap_addr({1'b0, gpr_m[CODE_H], gpr_m[CODE_L]});
   endfunction

   function automatic logic [7:0] read_reg(input logic [2:0] code);
      if (code == CODE_A) return acc_m;
      if (code == CODE_M) return mem_m[hl_addr()];
      return gpr_m[code];
   endfunction

   function automatic void write_reg(input logic [2:0] code, input logic [7:0] v);
      if (code == CODE_A) acc_m = v;
      else if (code == CODE_M) mem_m[hl_addr()] = v;
      else gpr_m[code] = v;
   endfunction

   // Apply one transfer word to the model and return the register snapshot it yields
   function automatic rsp_type execute_transfer(input logic [3:0] fn, input logic [2:0] dst,
         input logic [2:0] src, input logic [1:0] pair, input logic [7:0] imm,
         input logic [15:0] addr);
      rsp_type r;
      logic [15:0] a0;
      logic [15:0] a1;
      logic [15:0] pa;
      logic [7:0] t;
      r = '0;
      a0 = wrap_addr({1'b0, addr});
      a1 = wrap_addr({1'b0, addr} + 17'd1);
      pa = wrap_addr({1'b0, gpr_m[2 * pair], gpr_m[(2 * pair + 1) % 6]});
      case (fn)
         FN_MVI: write_reg(dst, imm);
         FN_MOV: begin
            // memory to memory is a no-op
            if (!(dst == CODE_M && src == CODE_M)) write_reg(dst, read_reg(src));
         end
         FN_LDA: acc_m = mem_m[a0];
         FN_LDAX: begin
            if (pair == PAIR_BC || pair == PAIR_DE) acc_m = mem_m[pa];
            else r.status = 1'b1;
         end
         FN_LXI: begin
            if (pair == PAIR_SP) begin
               r.status = 1'b1;
            end else begin
               gpr_m[2 * pair] = addr[15:8];
               gpr_m[2 * pair + 1] = addr[7:0];
            end
         end
         FN_LHLD: begin
            gpr_m[CODE_L] = mem_m[a0];
            gpr_m[CODE_H] = mem_m[a1];
         end
         FN_STA: mem_m[a0] = acc_m;
         FN_STAX: begin
            if (pair == PAIR_SP) r.status = 1'b1;
            else mem_m[pa] = acc_m;
         end
         FN_SHLD: begin
            mem_m[a0] = gpr_m[CODE_L];
            mem_m[a1] = gpr_m[CODE_H];
         end
         FN_XCHG: begin
            t = gpr_m[CODE_H];
            gpr_m[CODE_H] = gpr_m[CODE_D];
            gpr_m[CODE_D] = t;
            t = gpr_m[CODE_L];
            gpr_m[CODE_L] = gpr_m[CODE_E];
            gpr_m[CODE_E] = t;
         end
         FN_SPHL: sp_m = {gpr_m[CODE_H], gpr_m[CODE_L]};
         FN_XTHL: begin
            a0 = wrap_addr({1'b0, sp_m});
            a1 = wrap_addr({1'b0, sp_m} + 17'd1);
            t = gpr_m[CODE_L];
            gpr_m[CODE_L] = mem_m[a0];
            mem_m[a0] = t;
            t = gpr_m[CODE_H];
            gpr_m[CODE_H] = mem_m[a1];
            mem_m[a1] = t;
         end
         FN_MEMWRITE: mem_m[a0] = imm;
         FN_MEMREAD: r.read_byte = mem_m[a0];
         default: r.status = 1'b1;
      endcase
      r.acc = acc_m;
      r.reg_b = gpr_m[CODE_B];
      r.reg_c = gpr_m[CODE_C];
      r.reg_d = gpr_m[CODE_D];
      r.reg_e = gpr_m[CODE_E];
      r.reg_h = gpr_m[CODE_H];
      r.reg_l = gpr_m[CODE_L];
      r.stack_ptr = sp_m;
      return r;
   endfunction

   // Bias addresses toward both ends of memory so loads hit stored bytes
   function automatic logic [15:0] pick_addr();
      case ($urandom_range(0, 3))
         0, 1: return 16'($urandom_range(0, 15));
         2: return 16'($urandom_range(16'hFFF0, 16'hFFFF));
         default: return 16'($urandom);
      endcase
   endfunction

   // Offer one word, hold it until taken, then log its expected result
   task automatic send_word(input logic [3:0] fn, input logic [2:0] dst,
         input logic [2:0] src, input logic [1:0] pair, input logic [7:0] imm,
         input logic [15:0] addr);
      rsp_type want;
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      push <= 1'b1;
      req_func <= fn;
      req_dst_reg <= dst;
      req_src_reg <= src;
      req_reg_pair <= pair;
      req_imm_byte <= imm;
      req_addr_word <= addr;
      @(posedge clock);
      while (full) begin
         full_waits++;
         @(posedge clock);
      end
      want = execute_transfer(fn, dst, src, pair, imm, addr);
      transfer_results_q.push_back(want);
      words_sent++;
      if (want.status) illegal_words++;
   endtask

   task automatic send_random_word();
      send_word(4'($urandom_range(0, 15)), 3'($urandom), 3'($urandom), 2'($urandom),
                8'($urandom), pick_addr());
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
         input logic [15:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: word %0d %s mismatch, expected %h, actual %h",
                  $time, words_checked, name, want, got);
      end
   endtask

   // Drain results, with random stalls and a long hold-off on request
   always @(posedge clock) begin : rsp_drain
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (transfer_results_q.size() == 0) begin
            errors++;
            $display("%0t: result word with none expected, actual acc %h sp %h",
                     $time, rsp_acc, rsp_stack_ptr);
         end else begin
            want = transfer_results_q.pop_front();
            compare_field("status", 16'(want.status), 16'(rsp_status));
            compare_field("read_byte", 16'(want.read_byte), 16'(rsp_read_byte));
            compare_field("acc", 16'(want.acc), 16'(rsp_acc));
            compare_field("reg_b", 16'(want.reg_b), 16'(rsp_reg_b));
            compare_field("reg_c", 16'(want.reg_c), 16'(rsp_reg_c));
            compare_field("reg_d", 16'(want.reg_d), 16'(rsp_reg_d));
            compare_field("reg_e", 16'(want.reg_e), 16'(rsp_reg_e));
            compare_field("reg_h", 16'(want.reg_h), 16'(rsp_reg_h));
            compare_field("reg_l", 16'(want.reg_l), 16'(rsp_reg_l));
            compare_field("stack_ptr", want.stack_ptr, rsp_stack_ptr);
            words_checked++;
         end
      end
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         pop <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 6) - 1;
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   // Edge cases: wrap at the top of memory, M operand, illegal pairs, spare codes
   task automatic test_directed();
      send_word(FN_LXI, CODE_B, CODE_B, PAIR_HL, 8'h00, 16'hFFFF);
      send_word(FN_MVI, CODE_M, CODE_B, PAIR_BC, 8'hA5, 16'h0000);
      send_word(FN_MVI, CODE_A, CODE_B, PAIR_BC, 8'hFF, 16'h0000);
      send_word(FN_MOV, CODE_B, CODE_M, PAIR_BC, 8'h00, 16'h0000);
      send_word(FN_MOV, CODE_M, CODE_M, PAIR_BC, 8'h00, 16'h0000);
      send_word(FN_MVI, CODE_L, CODE_B, PAIR_BC, 8'h00, 16'h0000);
      send_word(FN_SHLD, CODE_B, CODE_B, PAIR_BC, 8'h00, 16'hFFFF);
      send_word(FN_LHLD, CODE_B, CODE_B, PAIR_BC, 8'h00, 16'hFFFF);
      send_word(FN_MVI, CODE_L, CODE_B, PAIR_BC, 8'hFF, 16'h0000);
      send_word(FN_SPHL, CODE_B, CODE_B, PAIR_BC, 8'h00, 16'h0000);
      send_word(FN_XTHL, CODE_B, CODE_B, PAIR_BC, 8'h00, 16'h0000);
      send_word(FN_LXI, CODE_B, CODE_B, PAIR_SP, 8'h00, 16'h1234);
      send_word(FN_LXI, CODE_B, CODE_B, PAIR_BC, 8'h00, 16'h0000);
      send_word(FN_LXI, CODE_B, CODE_B, PAIR_DE, 8'h00, 16'hFFFF);
      send_word(FN_LDAX, CODE_B, CODE_B, PAIR_BC, 8'h00, 16'h0000);
      send_word(FN_LDAX, CODE_B, CODE_B, PAIR_HL, 8'h00, 16'h0000);
      send_word(FN_MVI, CODE_A, CODE_B, PAIR_BC, 8'h3C, 16'h0000);
      send_word(FN_STAX, CODE_B, CODE_B, PAIR_DE, 8'h00, 16'h0000);
      send_word(FN_STAX, CODE_B, CODE_B, PAIR_SP, 8'h00, 16'h0000);
      send_word(FN_STA, CODE_B, CODE_B, PAIR_BC, 8'h00, 16'h8000);
      send_word(FN_LDA, CODE_B, CODE_B, PAIR_BC, 8'h00, 16'hFFFF);
      send_word(FN_XCHG, CODE_B, CODE_B, PAIR_BC, 8'h00, 16'h0000);
      send_word(FN_MEMWRITE, CODE_B, CODE_B, PAIR_BC, 8'h00, 16'h0000);
      send_word(FN_MEMREAD, CODE_B, CODE_B, PAIR_BC, 8'h00, 16'h8000);
      send_word(FN_SPARE_LO, CODE_A, CODE_M, PAIR_SP, 8'hFF, 16'hFFFF);
      send_word(FN_SPARE_HI, CODE_A, CODE_M, PAIR_SP, 8'hFF, 16'hFFFF);
   endtask

   task automatic test_random_mix();
      repeat (400) send_random_word();
   endtask

   // Hold the receiver off while words stream in until full rises
   task automatic test_backpressure();
      idle_enable = 1'b0;
      hold_request = 1'b1;
      repeat (16) send_random_word();
      idle_enable = 1'b1;
   endtask

   task automatic test_streaming();
      idle_enable = 1'b0;
      repeat (110) send_random_word();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_mix();
      test_backpressure();
      test_streaming();
      push <= 1'b0;
      while (transfer_results_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Ran %0d words (%0d with illegal codes) through all transfer functions;",
               words_sent, illegal_words);
      $display("checked %0d results, input held off by full for %0d cycles.",
               words_checked, full_waits);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Covers the memory clearing sweep after reset several times over
   initial begin
      #5_000_000;
      $display("Timeout with %0d results outstanding", transfer_results_q.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
